[sv/audio_frame_level_meter_macros.svh]
// Assertion helpers shared by the checker.
`ifndef AUDIO_FRAME_LEVEL_METER_MACROS_SVH
`define AUDIO_FRAME_LEVEL_METER_MACROS_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define AFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afl check failed");

// next-cycle implication
`define AFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afl check failed");

`endif

[sv/afl_pkg.sv]
package afl_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int MAG_W       = 16;
  localparam int SUM_W       = 28;
  localparam int CNT_W       = 13;
  localparam int MEAN_W      = 17;
  localparam int LVL_W       = 16;
  localparam int DB_OUT_W    = 15;
  localparam int DB_W        = 16;
  localparam int SCALE_W     = 7;
  localparam int THR_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int MUL_A_W     = 16;
  localparam int MUL_B_W     = 11;
  localparam int PROD_W      = 27;

  localparam int MAX_SAMPLES = 4096;
  localparam int FULL_SCALE  = 32768;
  localparam int FLOOR_DB    = -100;
  localparam int FLOOR_Q     = FLOOR_DB * 256;
  localparam int DB_PER_OCT  = 1541;    // 20*log10(2) in Q8.8
  localparam int SCALE_RST   = 1;
  localparam int THR_RST     = -80;
  localparam int SAT_HI      = 16383;
  localparam int SAT_LO      = -16384;

  // round(256*log2(1+i/32))
  localparam logic [7:0] LOG2_FRAC [32] = '{
    8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
    8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
    8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
    8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
  };

  // elaboration-time log2 in Q8.8, same rule as the runtime path
  function automatic int log2_q88_c(input int unsigned x);
    int          p;
    int unsigned idx;
    p = 0;
    for (int k = 0; k < 32; k++) begin
      if ((x >> k) != 0) p = k;
    end
    if (p >= 5) idx = (x >> (p - 5)) & 31;
    else        idx = (x << (5 - p)) & 31;
    return p * 256 + int'(LOG2_FRAC[idx]);
  endfunction

  localparam int LOG2_FS = log2_q88_c(FULL_SCALE);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_SCALE,
    CFG_SILENCE_THR
  } afl_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_DB,
    ST_OUT
  } afl_state_t;

  typedef enum logic [2:0] {
    DB_IDLE,
    DB_NORM,
    DB_LOG,
    DB_MUL1,
    DB_RND1,
    DB_MUL2,
    DB_RND2,
    DB_DONE
  } afl_db_state_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } afl_div_res_t;

  typedef struct packed {
    logic                       done;
    logic signed [DB_OUT_W-1:0] level_db;
    logic                       silent;
  } afl_db_res_t;

endpackage

[sv/afl_if.sv]
interface afl_in_if;
  import afl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_of_frame;
  modport source (output valid, sample, last_of_frame, input ready);
  modport sink   (input valid, sample, last_of_frame, output ready);
endinterface

interface afl_out_if;
  import afl_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [LVL_W-1:0]           mean_level;
  logic [LVL_W-1:0]           peak_level;
  logic signed [DB_OUT_W-1:0] level_db;
  logic                       silent;
  modport source (output valid, mean_level, peak_level, level_db, silent, input ready);
  modport sink   (input valid, mean_level, peak_level, level_db, silent, output ready);
endinterface

[sv/audio_frame_level_meter.sv]
// Channel  | Dir | Payload                                   | Request taken when
// in_s     | in  | sample, last_of_frame                     | valid && ready
// out_s    | out | mean_level, peak_level, level_db, silent  | valid && ready
// cfg      | in  | cfg_idx, cfg_wdata                        | cfg_we
//
// Samples that do not end a frame stream back to back while in ST_ACC.
// A frame end holds in_s.ready low through the 28 divider steps, the leading-one
// search, the log, multiply and round steps, and the handoff through ST_OUT.
// Reset (rst_n low, synchronous) clears accumulators, sequencers and out valid;
// level_scale returns to 1 and the threshold to -80 dB.
// A result waits in an output register; a second frame end stalls in ST_OUT.
module audio_frame_level_meter (
  input  logic                             clk,
  input  logic                             rst_n,
  afl_in_if.sink                           in_s,
  afl_out_if.source                        out_s,
  input  logic                             cfg_we,
  input  logic [afl_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [afl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import afl_pkg::*;

  afl_state_t             state_r, state_nxt;

  // config
  logic [SCALE_W-1:0]     scale_r;
  logic signed [THR_W-1:0] thr_r;

  // frame accumulators
  logic [SUM_W-1:0]       sum_r;
  logic [MAG_W-1:0]       peak_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [MAG_W-1:0]       peak_hold_r;
  logic [LVL_W-1:0]       mean_hold_r;

  // output register
  logic                       out_valid_r;
  logic [LVL_W-1:0]           mean_o_r;
  logic [LVL_W-1:0]           peak_o_r;
  logic signed [DB_OUT_W-1:0] lvl_o_r;
  logic                       silent_o_r;

  logic                   in_ready;
  logic                   accept;
  logic                   frame_end;
  logic [MAG_W-1:0]       mag_c;
  logic                   take_c;
  logic [SUM_W-1:0]       sum_nxt;
  logic [MAG_W-1:0]       peak_nxt;
  logic [CNT_W-1:0]       cnt_nxt;
  logic                   div_start;
  logic                   db_start;
  logic                   load_out;
  afl_div_res_t           div_res;
  afl_db_res_t            db_res;

  assign accept    = in_s.valid && in_ready;
  assign frame_end = accept && in_s.last_of_frame;

  // -32768 comes out as 32768 in the unsigned magnitude
  assign mag_c  = in_s.sample[SAMPLE_W-1] ? MAG_W'(~in_s.sample + 1'b1)
                                          : MAG_W'(in_s.sample);
  // samples past the frame limit are dropped, the end flag still counts
  assign take_c = cnt_r < CNT_W'(MAX_SAMPLES);

  always_comb begin
    sum_nxt  = sum_r;
    peak_nxt = peak_r;
    cnt_nxt  = cnt_r;
    if (take_c) begin
      sum_nxt = sum_r + SUM_W'(mag_c);
      cnt_nxt = cnt_r + 1'b1;
      if (mag_c > peak_r) peak_nxt = mag_c;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC: if (frame_end) state_nxt = ST_DIV;
      ST_DIV: if (div_res.done) state_nxt = ST_DB;
      ST_DB:  if (db_res.done) state_nxt = ST_OUT;
      ST_OUT: if (!out_valid_r || out_s.ready) state_nxt = ST_ACC;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    db_start  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_ACC: begin
        in_ready  = 1'b1;
        div_start = frame_end;
      end
      ST_DIV: db_start = div_res.done;
      ST_DB:  ;
      ST_OUT: load_out = !out_valid_r || out_s.ready;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      sum_r       <= '0;
      peak_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      scale_r     <= SCALE_W'(SCALE_RST);
      thr_r       <= THR_W'(THR_RST);
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        if (in_s.last_of_frame) begin
          sum_r  <= '0;
          peak_r <= '0;
          cnt_r  <= '0;
        end else begin
          sum_r  <= sum_nxt;
          peak_r <= peak_nxt;
          cnt_r  <= cnt_nxt;
        end
      end
      if (load_out)         out_valid_r <= 1'b1;
      else if (out_s.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_LEVEL_SCALE: scale_r <= cfg_wdata[SCALE_W-1:0];
          CFG_SILENCE_THR: thr_r   <= cfg_wdata[THR_W-1:0];
        endcase
      end
    end
  end

  // result holding registers, no reset needed
  always_ff @(posedge clk) begin
    if (frame_end)    peak_hold_r <= peak_nxt;
    if (div_res.done) mean_hold_r <= div_res.quotient[LVL_W-1:0];
    if (load_out) begin
      mean_o_r   <= mean_hold_r;
      peak_o_r   <= peak_hold_r;
      lvl_o_r    <= db_res.level_db;
      silent_o_r <= db_res.silent;
    end
  end

  afl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_nxt),
    .divisor  (cnt_nxt),
    .res      (div_res)
  );

  afl_db u_db (
    .clk   (clk),
    .rst_n (rst_n),
    .start (db_start),
    .mean  (div_res.quotient[MEAN_W-1:0]),
    .scale (scale_r),
    .thr   (thr_r),
    .res   (db_res)
  );

  assign in_s.ready       = in_ready;
  assign out_s.valid      = out_valid_r;
  assign out_s.mean_level = mean_o_r;
  assign out_s.peak_level = peak_o_r;
  assign out_s.level_db   = lvl_o_r;
  assign out_s.silent     = silent_o_r;

endmodule

[sv/afl_div.sv]
module afl_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [afl_pkg::SUM_W-1:0]     dividend,
  input  logic [afl_pkg::CNT_W-1:0]     divisor,
  output afl_pkg::afl_div_res_t         res
);
  import afl_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;

  logic [CNT_W:0]    trial;
  logic              ge;
  logic [CNT_W:0]    diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  // empty count reads as a zero mean
  assign res.done     = done_r;
  assign res.quotient = (dvs_r == '0) ? '0 : quo_r;

endmodule

[sv/afl_db.sv]
module afl_db (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [afl_pkg::MEAN_W-1:0]         mean,
  input  logic [afl_pkg::SCALE_W-1:0]        scale,
  input  logic signed [afl_pkg::THR_W-1:0]   thr,
  output afl_pkg::afl_db_res_t               res
);
  import afl_pkg::*;

  afl_db_state_t              state_r, state_nxt;
  logic [MEAN_W-1:0]          x_r;
  logic [4:0]                 p_r;
  logic                       zero_r;
  logic                       dneg_r;
  logic [MUL_A_W-1:0]         dmag_r;
  logic [PROD_W-1:0]          prod_r;
  logic signed [DB_W-1:0]     db_r;
  logic signed [DB_OUT_W-1:0] level_r;
  logic                       silent_r;

  logic [MUL_A_W-1:0]         mul_a;
  logic [MUL_B_W-1:0]         mul_b;
  logic [PROD_W-1:0]          mul_p;
  logic [PROD_W-1:0]          rnd;
  logic [PROD_W-9:0]          q;
  logic signed [DB_W-1:0]     d_c;
  logic signed [PROD_W-8:0]   cand;
  logic signed [DB_W-1:0]     db_c;
  logic signed [DB_W-1:0]     thr_q;
  logic signed [PROD_W-8:0]   scaled;
  logic                       done;

  // shared multiplier and rounder
  assign mul_p = mul_a * mul_b;
  assign rnd   = prod_r + PROD_W'(128);
  assign q     = rnd[PROD_W-1:8];

  assign d_c = $signed({3'b000, p_r, 8'h00})
             + $signed({8'h00, LOG2_FRAC[x_r[MEAN_W-2 -: 5]]})
             - DB_W'(LOG2_FS);

  assign cand  = dneg_r ? -$signed({1'b0, q}) : $signed({1'b0, q});
  assign thr_q = {thr, 8'h00};

  always_comb begin
    if (zero_r || cand < (PROD_W-7)'(FLOOR_Q)) db_c = DB_W'(FLOOR_Q);
    else                                       db_c = cand[DB_W-1:0];
  end

  always_comb begin
    scaled = db_r[DB_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DB_IDLE: if (start) state_nxt = DB_NORM;
      DB_NORM: if (zero_r || x_r[MEAN_W-1]) state_nxt = DB_LOG;
      DB_LOG:  state_nxt = DB_MUL1;
      DB_MUL1: state_nxt = DB_RND1;
      DB_RND1: state_nxt = DB_MUL2;
      DB_MUL2: state_nxt = DB_RND2;
      DB_RND2: state_nxt = DB_DONE;
      DB_DONE: state_nxt = DB_IDLE;
    endcase
  end

  // multiplier operands and done strobe
  always_comb begin
    mul_a = dmag_r;
    mul_b = MUL_B_W'(DB_PER_OCT);
    done  = 1'b0;
    unique case (state_r)
      DB_MUL2: begin
        mul_a = db_r[DB_W-1] ? MUL_A_W'(-db_r) : MUL_A_W'(db_r);
        mul_b = MUL_B_W'(scale);
      end
      DB_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DB_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DB_IDLE: if (start) begin
        x_r    <= mean;
        p_r    <= 5'(MEAN_W - 1);
        zero_r <= (mean == '0);
      end
      DB_NORM: if (!(zero_r || x_r[MEAN_W-1])) begin
        x_r <= {x_r[MEAN_W-2:0], 1'b0};
        p_r <= p_r - 1'b1;
      end
      DB_LOG: begin
        dneg_r <= d_c[DB_W-1];
        dmag_r <= d_c[DB_W-1] ? MUL_A_W'(-d_c) : MUL_A_W'(d_c);
      end
      DB_MUL1, DB_MUL2: prod_r <= mul_p;
      DB_RND1: begin
        db_r     <= db_c;
        silent_r <= db_c <= thr_q;
      end
      DB_RND2: begin
        if (scaled > (PROD_W-7)'(SAT_HI))      level_r <= DB_OUT_W'(SAT_HI);
        else if (scaled < (PROD_W-7)'(SAT_LO)) level_r <= DB_OUT_W'(SAT_LO);
        else                                   level_r <= scaled[DB_OUT_W-1:0];
      end
      DB_DONE: ;
    endcase
  end

  assign res.done     = done;
  assign res.level_db = level_r;
  assign res.silent   = silent_r;

endmodule

[sv/afl_checker.sv]
`include "audio_frame_level_meter_macros.svh"

module afl_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [afl_pkg::LVL_W-1:0]          mean_level,
  input logic [afl_pkg::LVL_W-1:0]          peak_level,
  input logic signed [afl_pkg::DB_OUT_W-1:0] level_db
);
  import afl_pkg::*;

  // frame end hands off to the divider, input stalls
  `AFL_ASSERT_NEXT(a_busy_after_end, in_valid && in_ready && in_last, !in_ready)

  // a mean never exceeds the frame's peak
  `AFL_ASSERT_NOW(a_mean_le_peak, out_valid, mean_level <= peak_level)

  // mean is at most full scale, so the level is never above 0 dB
  `AFL_ASSERT_NOW(a_db_nonpos, out_valid, level_db[DB_OUT_W-1] || level_db == '0)

  // stalled result holds
  `AFL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(mean_level) && $stable(level_db))

endmodule

bind audio_frame_level_meter afl_checker u_afl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .in_last    (in_s.last_of_frame),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .mean_level (out_s.mean_level),
  .peak_level (out_s.peak_level),
  .level_db   (out_s.level_db)
);

[bench/tb_audio_frame_level_meter.sv]
`timescale 1ns / 1ps

module tb_audio_frame_level_meter;
  import afl_pkg::*;

  // frame accumulation cap, and the dB floor in Q8.8
  localparam int          FRAME_CAP    = 4096;
  localparam int          FLOOR_Q88    = -100 * 256;
  localparam int unsigned FS_LEVEL     = 32768;
  localparam int          DB_OCT_Q88   = 1541;
  localparam int          SETTLE       = 60;    // margin for the back-end work after a frame end
  localparam int          CHOKE_CYCLES = 800;
  localparam int          PHASE_ITEMS  = 170;
  localparam int          RAND_PHASES  = 8;

  // round(256*log2(1+i/32)), mantissa part of the log
  localparam int unsigned FRAC_TAB [32] = '{
    0, 11, 22, 33, 44, 54, 63, 73, 82, 92, 100, 109, 118, 126, 134, 142,
    150, 157, 165, 172, 179, 186, 193, 200, 207, 213, 220, 226, 232, 238, 244, 250
  };

  // settings for the first random phases; extremes of both registers,
  // zero gain included (level_db must read 0 there)
  localparam int PHASE_GAIN [6] = '{100, 1, 0, 127, 37, 9};
  localparam int PHASE_THR  [6] = '{0, -100, -60, -128, 127, -90};

  // directed frames: silence, full-scale negative, full-scale positive,
  // unit level, truncated mean, mixed extremes, alternating bit patterns, small values
  localparam logic signed [15:0] DIR_SAMPLE [16] = '{
    16'sd0, -16'sd32768, 16'sd32767, 16'sd1,
    -16'sd1, 16'sd1, -16'sd1, 16'sd2,
    16'sd32767, -16'sd32768, 16'sd0,
    16'sh5555, 16'shAAAA,
    16'sd100, -16'sd3, 16'sd7
  };
  localparam logic DIR_LAST [16] = '{
    1'b1, 1'b1, 1'b1, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b1,
    1'b0, 1'b1,
    1'b0, 1'b0, 1'b1
  };

  typedef struct packed {
    logic [LVL_W-1:0]           mean;
    logic [LVL_W-1:0]           peak;
    logic signed [DB_OUT_W-1:0] db;
    logic                       silent;
  } level_rec_t;

  // Mirrors the meter: accumulates accepted samples, and on each frame end
  // queues the level record the block should report.
  class level_scoreboard;
    logic [27:0] abs_total;
    int unsigned peak_mag;
    int unsigned taken;
    int unsigned gain;
    int          thresh;
    level_rec_t  awaited [$];
    int          errors;
    int          samples_seen;
    int          samples_dropped;
    int          frames_checked;

    function new();
      abs_total = '0;
      peak_mag = 0;
      taken = 0;
      gain = 1;
      thresh = -80;
      errors = 0;
      samples_seen = 0;
      samples_dropped = 0;
      frames_checked = 0;
    endfunction

    function void set_gain(int unsigned g);
      gain = g & 'h7F;
    endfunction

    function void set_thresh(int t);
      thresh = t;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Q8.8 log2: leading-one position plus a 5-bit mantissa lookup
    function int log2_q88(int unsigned x);
      int          top;
      int unsigned idx;
      top = 0;
      while ((x >> (top + 1)) != 0) top++;
      if (top >= 5) idx = (x >> (top - 5)) & 31;
      else          idx = (x << (5 - top)) & 31;
      return top * 256 + int'(FRAC_TAB[idx]);
    endfunction

    function int mean_to_db_q88(int unsigned mean);
      int          d;
      int unsigned m;
      int          q;
      if (mean == 0) return FLOOR_Q88;
      d = log2_q88(mean) - log2_q88(FS_LEVEL);
      m = int'(d < 0 ? -d : d) * DB_OCT_Q88;
      q = int'((m + 128) >> 8);
      if (d < 0) q = -q;
      if (q < FLOOR_Q88) q = FLOOR_Q88;
      return q;
    endfunction

    function void note_sample(logic signed [15:0] s, logic last);
      int unsigned mag;
      int unsigned mean;
      int unsigned vmag;
      int          db;
      int          lvl;
      level_rec_t  rec;
      mag = (s < 0) ? int'(-int'(s)) : int'(s);
      samples_seen++;
      if (taken < FRAME_CAP) begin
        abs_total = abs_total + 28'(mag);
        if (mag > peak_mag) peak_mag = mag;
        taken++;
      end else begin
        samples_dropped++;
      end
      if (!last) return;

      mean = (taken == 0) ? 0 : abs_total / taken;
      db = mean_to_db_q88(mean);
      vmag = int'(db < 0 ? -db : db) * gain;
      lvl = int'((vmag + 128) >> 8);
      if (db < 0) lvl = -lvl;
      if (lvl < -16384) lvl = -16384;
      if (lvl > 16383) lvl = 16383;

      rec.mean = mean[LVL_W-1:0];
      rec.peak = peak_mag[LVL_W-1:0];
      rec.db = lvl[DB_OUT_W-1:0];
      rec.silent = (db <= thresh * 256);
      awaited.push_back(rec);

      abs_total = '0;
      peak_mag = 0;
      taken = 0;
    endfunction

    function void check_level(logic [LVL_W-1:0] mean, logic [LVL_W-1:0] peak,
                              logic signed [DB_OUT_W-1:0] db, logic silent);
      level_rec_t want;
      if (awaited.size() == 0) begin
        $error("level result with no frame pending: mean=%0d peak=%0d db=%0d silent=%0d",
               mean, peak, db, silent);
        errors++;
        return;
      end
      want = awaited.pop_front();
      frames_checked++;
      if (mean !== want.mean) begin
        $error("mean_level: expected %0d, got %0d", want.mean, mean);
        errors++;
      end
      if (peak !== want.peak) begin
        $error("peak_level: expected %0d, got %0d", want.peak, peak);
        errors++;
      end
      if (db !== want.db) begin
        $error("level_db: expected %0d, got %0d", want.db, db);
        errors++;
      end
      if (silent !== want.silent) begin
        $error("silent: expected %0d, got %0d", want.silent, silent);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  afl_in_if  in_if ();
  afl_out_if out_if ();

  level_scoreboard sb;

  // pacing state shared by the request driver and the result sink
  bit pace_on = 1'b1;
  int send_calm = 0;
  int recv_calm = 0;
  bit choke_armed = 1'b0;
  bit choke_done = 1'b0;
  int settings_used = 1;

  audio_frame_level_meter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Random wait before a request or a result, with occasional calm
  // stretches of no waiting at all.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(15, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Sample styles: 0 silence, 1 full random, 2 full-scale extremes,
  // otherwise bounded by 2^amp so the mean sweeps every octave.
  function automatic logic signed [15:0] draw_sample(int style, int amp);
    int m;
    case (style)
      0: return 16'sd0;
      1: return 16'($urandom);
      2: return ($urandom_range(0, 1) == 1) ? -16'sd32768 : 16'sd32767;
      default: begin
        m = $urandom_range(0, 1 << amp);
        if ($urandom_range(0, 1) == 1) m = -m;
        else if (m > 32767) m = 32767;
        return 16'(m);
      end
    endcase
  endfunction

  // One sample request; called on a clock edge, returns on the edge that
  // takes it. Valid stays high across back-to-back requests.
  task automatic send_sample(input logic signed [15:0] s, input logic last);
    int gap;
    gap = pace_on ? draw_wait(send_calm) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    in_if.last_of_frame <= last;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s, last);
  endtask

  // Both registers in consecutive cycles; the write enable is raised once
  // and dropped once so no edge sees a glitch.
  task automatic set_levels(input int gain, input int thr);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_LEVEL_SCALE;
    cfg_wdata <= CFG_DATA_W'(gain);
    @(posedge clk);
    cfg_idx <= CFG_SILENCE_THR;
    cfg_wdata <= CFG_DATA_W'(thr);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_gain(gain);
    sb.set_thresh(int'($signed(8'(thr))));
    settings_used++;
  endtask

  // Every pending frame reported, then let the back stage go quiet.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Result sink: random back-pressure, plus one long hold-off once armed so
  // that the output register fills, a second frame end parks, and the
  // input side stalls while requests keep being offered.
  initial begin : result_sink
    int stall;
    out_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = draw_wait(recv_calm);
      if (choke_armed && !choke_done) begin
        stall = CHOKE_CYCLES;
        choke_done = 1'b1;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      sb.check_level(out_if.mean_level, out_if.peak_level, out_if.level_db,
                     out_if.silent);
    end
  end

  initial begin : stimulus
    int len;
    int style;
    int amp;
    int sent;
    int pick;
    sb = new();

    rst_n <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.sample <= '0;
    in_if.last_of_frame <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_LEVEL_SCALE;
    cfg_wdata <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset settings (gain 1, threshold -80 dB).
    for (int i = 0; i < 16; i++) send_sample(DIR_SAMPLE[i], DIR_LAST[i]);
    in_if.valid <= 1'b0;

    // Random phases, each under its own settings. Mostly short frames so
    // frame ends come often; a few long ones.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_drained();
      if (ph < 6) set_levels(PHASE_GAIN[ph], PHASE_THR[ph]);
      else set_levels($urandom_range(1, 100), -int'($urandom_range(0, 100)));
      if (ph == 1) choke_armed = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(1, 8);
        else if (pick < 95) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 200);
        style = $urandom_range(0, 9);
        amp = $urandom_range(0, 15);
        for (int i = 0; i < len; i++) send_sample(draw_sample(style, amp), i == len - 1);
        sent += len;
      end
      in_if.valid <= 1'b0;
    end

    wait_drained();
    if (sb.pending() != 0) begin
      $error("%0d frame results never arrived", sb.pending());
      sb.errors++;
    end

    $display("run covered %0d samples (%0d dropped past the frame cap), %0d frames checked",
             sb.samples_seen, sb.samples_dropped, sb.frames_checked);
    $display("under %0d register settings, with one long output stall", settings_used);
    if (sb.errors == 0) begin
      $display("tb_audio_frame_level_meter: clean");
    end else begin
      $display("tb_audio_frame_level_meter: errors");
    end
    $finish;
  end

  // hard stop, several times the slowest legal run
  initial begin : watchdog
    #1000000;
    $display("tb_audio_frame_level_meter: errors");
    $finish;
  end

endmodule
